// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the header parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ihsp_pkg.sv -----
// Shared constants, types and the header decode function of the header parser.
package ihsp_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int HEAD_LENGTH = 24;
  localparam int WIN_LEN     = 12;
  localparam int WIN_START   = 2;
  localparam int WIN_LAST    = WIN_START + WIN_LEN - 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  // One bit wider than the count so a segment end past the last countable byte never wraps.
  typedef logic [COUNT_WIDTH:0]   seg_end_t;
  typedef logic [HEAD_LENGTH-1:0][7:0] head_t;
  typedef logic [WIN_LEN-1:0][7:0]     win_t;

  localparam count_t   COUNT_MAX     = '1;
  localparam seg_end_t SEG_END_RESET = seg_end_t'(WIN_LAST);

  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_JPEG = 2'd1;
  localparam logic [1:0] FMT_GIF  = 2'd2;
  localparam logic [1:0] FMT_PNG  = 2'd3;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_APP0   = 8'hE0;
  localparam logic [7:0] SOF_A_LO    = 8'hC0;
  localparam logic [7:0] SOF_A_HI    = 8'hC3;
  localparam logic [7:0] SOF_B_LO    = 8'hC9;
  localparam logic [7:0] SOF_B_HI    = 8'hCB;
  localparam logic [7:0] PNG_SIG0    = 8'h89;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_SUB     = 8'h1A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  image_format;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } out_word_t;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return ((m >= SOF_A_LO) && (m <= SOF_A_HI)) || ((m >= SOF_B_LO) && (m <= SOF_B_HI));
  endfunction

  // Decodes the merged header bytes into a result word.
  function automatic out_word_t decode_header(input head_t b, input logic long_enough);
    out_word_t r;
    r = '0;
    if (long_enough) begin
      if (b[0] == MARK_PREFIX && b[1] == MARK_SOI && b[2] == MARK_PREFIX) begin
        r.found        = 1'b1;
        r.image_format = FMT_JPEG;
        r.image_height = {16'h0000, b[7], b[8]};
        r.image_width  = {16'h0000, b[9], b[10]};
      end else if (b[0] == "G" && b[1] == "I" && b[2] == "F") begin
        r.found        = 1'b1;
        r.image_format = FMT_GIF;
        r.image_width  = {16'h0000, b[7], b[6]};
        r.image_height = {16'h0000, b[9], b[8]};
      end else if (b[0] == PNG_SIG0 && b[1] == "P" && b[2] == "N" && b[3] == "G" &&
                   b[4] == CHR_CR && b[5] == CHR_LF && b[6] == CHR_SUB && b[7] == CHR_LF &&
                   b[12] == "I" && b[13] == "H" && b[14] == "D" && b[15] == "R") begin
        r.found        = 1'b1;
        r.image_format = FMT_PNG;
        r.image_width  = {b[16], b[17], b[18], b[19]};
        r.image_height = {b[20], b[21], b[22], b[23]};
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/ihsp_stream_if.sv -----
// Valid/ready stream interfaces for the byte input and the result output.
interface ihsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface ihsp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  image_format;
  logic [31:0] image_width;
  logic [31:0] image_height;

  modport source (output valid, output found, output image_format, output image_width,
                  output image_height, input ready);
  modport sink   (input valid, input found, input image_format, input image_width,
                  input image_height, output ready);
endinterface

// ----- rtl/ihsp_parser.sv -----
// Per-file parser state: byte count, header capture, byte window and JPEG segment walk.
`include "assert_macros.svh"

module ihsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  ihsp_pkg::in_word_t in_word,
  output ihsp_pkg::out_word_t res
);
  import ihsp_pkg::*;

  count_t   cnt_r, cnt_nxt;
  head_t    head_r, head_nxt;
  win_t     recent_r, recent_nxt;
  win_t     win_r, win_nxt;
  seg_end_t seg_end_r, seg_end_nxt;
  logic     scan_r, scan_nxt;

  logic     known;
  logic     first_win;
  logic     jfif;
  logic     take;
  logic     scan_now;
  seg_end_t seg_end_now;
  count_t   cnt_inc;
  head_t    merged;

  always_comb begin
    known = (cnt_r != COUNT_MAX);

    head_nxt = head_r;
    for (int i = 0; i < HEAD_LENGTH; i++) begin
      if (known && cnt_r == count_t'(i)) begin
        head_nxt[i] = in_word.data_byte;
      end
    end

    // Newest byte enters at the top; element 0 is the oldest of the last twelve.
    recent_nxt = {in_word.data_byte, recent_r[WIN_LEN-1:1]};
    cnt_inc    = known ? cnt_r + count_t'(1) : cnt_r;

    first_win = known && (cnt_r == count_t'(WIN_LAST));
    jfif = (head_nxt[0] == MARK_PREFIX) && (head_nxt[1] == MARK_SOI) &&
           (head_nxt[2] == MARK_PREFIX) && (head_nxt[3] == MARK_APP0) &&
           (head_nxt[6] == "J") && (head_nxt[7] == "F") &&
           (head_nxt[8] == "I") && (head_nxt[9] == "F");

    win_nxt     = first_win ? head_nxt[WIN_LAST:WIN_START] : win_r;
    scan_now    = (first_win && jfif) ? 1'b1 : scan_r;
    seg_end_now = (first_win && jfif) ? SEG_END_RESET : seg_end_r;
    scan_nxt    = scan_now;
    seg_end_nxt = seg_end_now;

    // The pending segment window is complete when its last byte arrives.
    take = known && scan_now && ({1'b0, cnt_r} == seg_end_now);
    if (take) begin
      win_nxt = recent_nxt;
      if (recent_nxt[0] != MARK_PREFIX || is_frame_marker(recent_nxt[1])) begin
        scan_nxt = 1'b0;
      end else begin
        seg_end_nxt = seg_end_now + seg_end_t'(2) + seg_end_t'({recent_nxt[2], recent_nxt[3]});
      end
    end

    merged = head_nxt;
    merged[WIN_LAST:WIN_START] = win_nxt;
    res = decode_header(merged, cnt_inc >= count_t'(HEAD_LENGTH));

    cnt_nxt = cnt_inc;
    // The last byte of a file returns the walk to its starting state.
    if (in_word.is_last) begin
      cnt_nxt     = '0;
      scan_nxt    = 1'b0;
      seg_end_nxt = SEG_END_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      scan_r    <= 1'b0;
      seg_end_r <= SEG_END_RESET;
    end else if (acc) begin
      cnt_r     <= cnt_nxt;
      scan_r    <= scan_nxt;
      seg_end_r <= seg_end_nxt;
    end
  end

  // Every byte read back from these is written in the current file before it is used.
  always_ff @(posedge clk) begin
    if (acc) begin
      head_r   <= head_nxt;
      recent_r <= recent_nxt;
      win_r    <= win_nxt;
    end
  end

  `ASSERT_NEXT(a_last_clears_count, acc && in_word.is_last, cnt_r == '0, "count not cleared after last word")
  `ASSERT_IMPLIES(a_scan_after_window, scan_r, cnt_r > count_t'(WIN_LAST), "segment walk active too early")
  `ASSERT_ALWAYS(a_seg_end_floor, seg_end_r >= SEG_END_RESET, "segment end below first window")

endmodule

// ----- rtl/image_header_size_parser.sv -----
// Top level of the image header size parser: byte stream in, one size result per file out.
//
//   channel  | dir | words                                   | handshake
//   in_if    | in  | data_byte[7:0], is_last                 | valid/ready
//   out_if   | out | found, image_format[1:0], width, height | valid/ready
//
// One input word is taken every cycle while in_if.ready is high; the parser state updates
// in the cycle a word is taken. The result for a file is computed from the last word and
// shows on out_if once it is held in the output register.
// A two-entry output stage (output register plus skid register) lets input continue while
// a result waits; in_if.ready drops only while the skid register holds a second result.
// Reset is synchronous and active low; it clears the byte count, the walk state and both
// output valid flags.
`include "assert_macros.svh"

module image_header_size_parser (
  input  logic              clk,
  input  logic              rst_n,
  ihsp_in_if.sink           in_if,
  ihsp_out_if.source        out_if
);
  import ihsp_pkg::*;

  in_word_t  in_word;
  out_word_t res;
  out_word_t out_r;
  out_word_t skid_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      acc;
  logic      push;
  logic      out_free;

  assign in_word  = '{data_byte: in_if.data_byte, is_last: in_if.is_last};
  assign in_if.ready = !skid_valid_r;
  assign acc      = in_if.valid && in_if.ready;
  // Only the word that ends a file produces a result.
  assign push     = acc && in_if.is_last;
  assign out_free = !out_valid_r || out_if.ready;

  ihsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_word (in_word),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.found        = out_r.found;
  assign out_if.image_format = out_r.image_format;
  assign out_if.image_width  = out_r.image_width;
  assign out_if.image_height = out_r.image_height;

  `ASSERT_IMPLIES(a_skid_needs_out, skid_valid_r, out_valid_r, "skid word without output word")
  `ASSERT_NEXT(a_stalled_out_stays, out_valid_r && !out_if.ready, out_valid_r, "stalled result dropped")
  `ASSERT_NEXT(a_push_to_skid, push && out_valid_r && !out_if.ready, skid_valid_r, "result lost while stalled")

endmodule
